// ===== hw/rtl/csas_pkg.sv =====
//------------------------------------------------------------------------------
// csas_pkg
// Shared types, widths and state codes for the slot assignment solver.
//------------------------------------------------------------------------------
`default_nettype none
package csas_pkg;
  localparam int SLOTS      = 8;
  localparam int IDX_W      = 3;
  localparam int COL_W      = 4;             // columns 0..SLOTS, 0 is the dummy
  localparam int COST_WIDTH = 32;
  localparam int POT_W      = 40;

  typedef struct packed {
    logic [IDX_W-1:0]             row;
    logic [IDX_W-1:0]             col;
    logic signed [COST_WIDTH-1:0] cost;
    logic                         last_entry;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] assigned_row;
    logic [IDX_W-1:0] slot;
    logic             last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_ROWINIT, ST_MARK, ST_SCAN, ST_UPD, ST_CHECK,
    ST_AUG, ST_OUT
  } state_t;

  localparam logic signed [POT_W-1:0] BIG_SLACK = {1'b0, {(POT_W-1){1'b1}}};
endpackage
`default_nettype wire

// ===== hw/rtl/csas_mem.sv =====
//------------------------------------------------------------------------------
// csas_mem
// Cost matrix storage, one write and one registered read per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module csas_mem (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [2*csas_pkg::IDX_W-1:0]          waddr,
  input  wire logic signed [csas_pkg::COST_WIDTH-1:0] wdata,
  input  wire logic [2*csas_pkg::IDX_W-1:0]          raddr,
  output logic signed [csas_pkg::COST_WIDTH-1:0]     rdata
);
  import csas_pkg::*;
  logic signed [COST_WIDTH-1:0] mem [SLOTS*SLOTS];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/child_slot_assignment_solver_core.sv =====
//------------------------------------------------------------------------------
// child_slot_assignment_solver_core
// Hungarian-method assignment of up to 8 rows to 8 slots.
//------------------------------------------------------------------------------
// Usage: cost entries arrive on the in_ channel, one item per cycle, each
// written into the cost matrix. An item with last_entry set starts the
// solve; its row plus one is the number of rows. While solving, in_ready is
// low. One pass of a row phase picks the row, scans the 8 columns through a
// shared subtract/compare unit (the matrix has a single registered read
// port, so each column's data arrives after its address is issued), updates
// the potentials and tests for a free column. Row i needs at most i passes,
// a setup step and a walk back along the augmenting path.
// Results come out one item per row in row order on the out_ channel; the
// output register holds an item until out_ready takes it, and the block
// waits in that step while the receiver stalls. After the last result the
// block returns to loading. Reset (rst_n low, synchronous) returns to the
// loading state; the matrix keeps undefined contents until written.
//------------------------------------------------------------------------------
`default_nettype none
module child_slot_assignment_solver_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire csas_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output csas_pkg::out_item_t       out_data
);
  import csas_pkg::*;

  state_t state_r, state_nxt;

  // Solver state. Index 0 is the dummy column / row.
  logic signed [POT_W-1:0] u_r [SLOTS+1];
  logic signed [POT_W-1:0] v_r [SLOTS+1];
  logic signed [POT_W-1:0] minv_r [SLOTS+1];
  logic [COL_W-1:0] p_r [SLOTS+1];
  logic [COL_W-1:0] way_r [SLOTS+1];
  logic [SLOTS:0]   used_r;

  logic [COL_W-1:0] rows_r, i_r, j0_r, j1_r, cnt_r, guard_r;
  logic signed [POT_W-1:0] delta_r;
  logic [COL_W-1:0] i0_r;
  logic             rd_pend_r;

  // Memory.
  logic                         mem_we;
  logic [2*IDX_W-1:0]           raddr;
  logic signed [COST_WIDTH-1:0] rdata;
  assign mem_we = in_valid && in_ready;
  csas_mem u_mem (
    .clk(clk), .we(mem_we), .waddr({in_data.row, in_data.col}),
    .wdata(in_data.cost), .raddr(raddr), .rdata(rdata)
  );

  // In ST_SCAN cnt_r walks columns 1..SLOTS as issue addresses; data arrives
  // in the next cycle and is processed for that column, held in pc_r.
  logic [COL_W-1:0] issue_col;
  assign issue_col = cnt_r;
  logic [IDX_W-1:0] i0m1, colm1;
  assign i0m1  = IDX_W'(i0_r - 4'd1);
  assign colm1 = IDX_W'(issue_col - 4'd1);
  assign raddr = {i0m1, colm1};

  logic [COL_W-1:0] pc_r;  // column whose data is in rdata
  logic signed [POT_W-1:0] cur, ms_new;
  assign cur = POT_W'(rdata) - u_r[i0_r] - v_r[pc_r];
  always_comb begin
    ms_new = minv_r[pc_r];
    if (cur < ms_new) ms_new = cur;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:    if (mem_we && in_data.last_entry) state_nxt = ST_CLEAR;
      ST_CLEAR:   state_nxt = ST_ROWINIT;
      ST_ROWINIT: state_nxt = ST_MARK;
      ST_MARK:    state_nxt = ST_SCAN;
      ST_SCAN:    if (rd_pend_r && pc_r == COL_W'(SLOTS)) state_nxt = ST_UPD;
      ST_UPD: begin
        if (j1_r == '0) state_nxt = ST_AUG;
        else if (cnt_r == COL_W'(SLOTS)) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (p_r[j0_r] != '0 && guard_r <= COL_W'(SLOTS)) state_nxt = ST_MARK;
        else state_nxt = ST_AUG;
      end
      ST_AUG: begin
        if (j0_r == '0 || guard_r > COL_W'(SLOTS)) begin
          state_nxt = (i_r == rows_r) ? ST_OUT : ST_ROWINIT;
        end
      end
      ST_OUT: if (out_valid && out_ready && out_data.last_result) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_LOAD);
  end

  // Slot lookup for a row: search the small owner vector.
  logic [IDX_W-1:0] slot_sel;
  always_comb begin
    slot_sel = '0;
    for (int j = 1; j <= SLOTS; j++) begin
      if (p_r[j] == COL_W'(cnt_r + 4'd1)) slot_sel = IDX_W'(j - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          if (mem_we && in_data.last_entry) begin
            rows_r <= {1'b0, in_data.row} + 4'd1;
            i_r    <= '0;
          end
        end
        ST_CLEAR: begin
          for (int j = 0; j <= SLOTS; j++) begin
            u_r[j] <= '0; v_r[j] <= '0; p_r[j] <= '0; way_r[j] <= '0;
          end
        end
        ST_ROWINIT: begin
          i_r <= i_r + 4'd1;
          p_r[0] <= i_r + 4'd1;
          j0_r <= '0;
          guard_r <= '0;
          used_r <= '0;
          for (int j = 0; j <= SLOTS; j++) minv_r[j] <= BIG_SLACK;
        end
        ST_MARK: begin
          used_r[j0_r] <= 1'b1;
          i0_r <= p_r[j0_r];
          delta_r <= BIG_SLACK;
          j1_r <= '0;
          cnt_r <= 4'd1;
          rd_pend_r <= 1'b0;
        end
        ST_SCAN: begin
          if (cnt_r <= COL_W'(SLOTS)) begin
            pc_r <= cnt_r;
            cnt_r <= cnt_r + 4'd1;
            rd_pend_r <= 1'b1;
          end
          if (rd_pend_r && !used_r[pc_r]) begin
            if (cur < minv_r[pc_r]) begin
              minv_r[pc_r] <= cur;
              way_r[pc_r]  <= j0_r;
            end
            if (ms_new < delta_r) begin
              delta_r <= ms_new;
              j1_r    <= pc_r;
            end
          end
          if (rd_pend_r && pc_r == COL_W'(SLOTS)) begin
            cnt_r <= '0;
            rd_pend_r <= 1'b0;
          end
        end
        ST_UPD: begin
          if (j1_r != '0) begin
            if (used_r[cnt_r]) begin
              u_r[p_r[cnt_r]] <= u_r[p_r[cnt_r]] + delta_r;
              v_r[cnt_r] <= v_r[cnt_r] - delta_r;
            end else begin
              minv_r[cnt_r] <= minv_r[cnt_r] - delta_r;
            end
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == COL_W'(SLOTS)) begin
              j0_r <= j1_r;
              guard_r <= guard_r + 4'd1;
            end
          end else begin
            guard_r <= '0;
          end
        end
        ST_CHECK: begin
          if (!(p_r[j0_r] != '0 && guard_r <= COL_W'(SLOTS))) guard_r <= '0;
        end
        ST_AUG: begin
          if (j0_r != '0 && guard_r <= COL_W'(SLOTS)) begin
            p_r[j0_r] <= p_r[way_r[j0_r]];
            j0_r <= way_r[j0_r];
            guard_r <= guard_r + 4'd1;
          end else if (i_r == rows_r) begin
            cnt_r <= '0;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && out_data.last_result) begin
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              out_data.assigned_row <= IDX_W'(cnt_r);
              out_data.slot <= slot_sel;
              out_data.last_result <= (cnt_r + 4'd1 == rows_r);
              cnt_r <= cnt_r + 4'd1;
            end
          end
        end
        default: ;
      endcase
      if (state_r != ST_OUT && out_valid && out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire
